[rtl/dwii_pkg.sv]
package dwii_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int MODE_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int FILL_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_BACK  = 3'd5,
        MODE_INSERT     = 3'd6,
        MODE_REMOVE     = 3'd7
    } mode_t;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // physical slot of logical index idx (idx <= DEPTH)
    function automatic addr_t slot_of(addr_t head, cnt_t idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

[rtl/dwii_ram.sv]
module dwii_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/deque_with_indexed_insert_core.sv]
// Push, tail insert, refused: to done; pop/peek: via read state; insert/remove: via shifts.
// One request in flight; the next is taken once the result is in the output register.
// Cost is set by the ring RAM, one read and one write per cycle: one entry moved per cycle.
// Reset (aresetn, sync, active low): empty, head at slot 0, no result pending.
// RAM contents are not cleared; only occupied entries are ever read.
module deque_with_indexed_insert_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dwii_pkg::MODE_W-1:0]  s_mode,
    input  logic [dwii_pkg::VAL_W-1:0]   s_item_value,
    input  logic [dwii_pkg::POS_W-1:0]   s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [dwii_pkg::VAL_W-1:0]   m_read_value,
    output logic [dwii_pkg::FILL_W-1:0]  m_fill
);
    import dwii_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_INS,
        ST_INS_LAST,
        ST_REM_FIRST,
        ST_REM,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    addr_t              head_reg, head_next;
    cnt_t               count_reg, count_next;
    cnt_t               idx_reg, idx_next;
    cnt_t               pos_reg, pos_next;
    data_t              val_reg, val_next;
    logic               ok_reg, ok_next;
    data_t              rd_reg, rd_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg, m_ok_next;
    logic [VAL_W-1:0]   m_read_value_reg, m_read_value_next;
    logic [FILL_W-1:0]  m_fill_reg, m_fill_next;

    logic               we, re;
    addr_t              waddr, raddr;
    data_t              wdata, rdata;

    logic               acc, full, empty;
    addr_t              head_dec, head_inc;
    logic [31:0]        pos_w, cnt_w;
    data_t              val_in;
    cnt_t               pos_in;

    dwii_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign acc     = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign pos_w   = 32'(s_position);
    assign cnt_w   = 32'(count_reg);
    assign val_in  = DATA_WIDTH'(s_item_value);
    assign pos_in  = CNT_W'(s_position);

    always_comb begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        val_next          = val_reg;
        ok_next           = ok_reg;
        rd_next           = rd_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_ok_next         = m_ok_reg;
        m_read_value_next = m_read_value_reg;
        m_fill_next       = m_fill_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        re    = 1'b0;
        raddr = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    ok_next    = 1'b0;
                    rd_next    = '0;
                    val_next   = val_in;
                    pos_next   = pos_in;
                    state_next = ST_DONE;
                    unique case (mode_t'(s_mode))
                        MODE_PUSH_FRONT: begin
                            if (!full) begin
                                head_next  = head_dec;
                                we         = 1'b1;
                                waddr      = head_dec;
                                wdata      = val_in;
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (!full) begin
                                we         = 1'b1;
                                waddr      = slot_of(head_reg, count_reg);
                                wdata      = val_in;
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (!empty) begin
                                re         = 1'b1;
                                raddr      = head_reg;
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                ok_next    = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (!empty) begin
                                re         = 1'b1;
                                raddr      = slot_of(head_reg, count_reg - 1'b1);
                                count_next = count_reg - 1'b1;
                                ok_next    = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        MODE_PEEK_FRONT: begin
                            if (!empty) begin
                                re         = 1'b1;
                                raddr      = head_reg;
                                ok_next    = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        MODE_PEEK_BACK: begin
                            if (!empty) begin
                                re         = 1'b1;
                                raddr      = slot_of(head_reg, count_reg - 1'b1);
                                ok_next    = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        MODE_INSERT: begin
                            if (!full && pos_w <= cnt_w) begin
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                                if (pos_w == cnt_w) begin
                                    we    = 1'b1;
                                    waddr = slot_of(head_reg, count_reg);
                                    wdata = val_in;
                                end else begin
                                    re         = 1'b1;
                                    raddr      = slot_of(head_reg, count_reg - 1'b1);
                                    idx_next   = count_reg;
                                    state_next = ST_INS;
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            if (pos_w < cnt_w) begin
                                count_next = count_reg - 1'b1;
                                ok_next    = 1'b1;
                                re         = 1'b1;
                                raddr      = slot_of(head_reg, pos_in);
                                idx_next   = pos_in;
                                state_next = ST_REM_FIRST;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_next    = rdata;
                state_next = ST_DONE;
            end
            // move entries one place back, from the tail down to the insert position
            ST_INS: begin
                we    = 1'b1;
                waddr = slot_of(head_reg, idx_reg);
                wdata = rdata;
                if (idx_reg > pos_reg + 1'b1) begin
                    re       = 1'b1;
                    raddr    = slot_of(head_reg, idx_reg - 2'd2);
                    idx_next = idx_reg - 1'b1;
                end else begin
                    state_next = ST_INS_LAST;
                end
            end
            ST_INS_LAST: begin
                we         = 1'b1;
                waddr      = slot_of(head_reg, pos_reg);
                wdata      = val_reg;
                state_next = ST_DONE;
            end
            // count_reg already holds the reduced count here
            ST_REM_FIRST: begin
                rd_next = rdata;
                if (pos_reg < count_reg) begin
                    re         = 1'b1;
                    raddr      = slot_of(head_reg, pos_reg + 1'b1);
                    state_next = ST_REM;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_REM: begin
                we    = 1'b1;
                waddr = slot_of(head_reg, idx_reg);
                wdata = rdata;
                if (idx_reg + 1'b1 < count_reg) begin
                    re       = 1'b1;
                    raddr    = slot_of(head_reg, idx_reg + 2'd2);
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_ok_next         = ok_reg;
                    m_read_value_next = VAL_W'(rd_reg);
                    m_fill_next       = FILL_W'(count_reg);
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg          <= idx_next;
        pos_reg          <= pos_next;
        val_reg          <= val_next;
        ok_reg           <= ok_next;
        rd_reg           <= rd_next;
        m_ok_reg         <= m_ok_next;
        m_read_value_reg <= m_read_value_next;
        m_fill_reg       <= m_fill_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_read_value = m_read_value_reg;
    assign m_fill       = m_fill_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_read_value == '0)
        else $error("refused request returned data");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        we && re |-> waddr != raddr)
        else $error("read and write to same slot in one cycle");

    a_fill_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && (!m_valid || m_ready) |=> m_fill == FILL_W'(count_reg))
        else $error("reported fill differs from entry count");

endmodule
